// File: sv/mmul_pkg.sv
// shared types and constants for the matrix multiply core
// no dependencies; used by every module of the block except mmul_ram
`timescale 1ns / 1ps

package mmul_pkg;

   localparam int CFG_W     = 4;   // width of a dimension register
   localparam int CSR_IDX_W = 2;
   localparam int CMD_W     = 2;
   localparam int ROW_W     = 3;
   localparam int COL_W     = 3;
   localparam int ELEM_IN_W = 16;  // element_value port width
   localparam int ELEM_MAX_W = 32; // widest element the store may hold
   localparam int OUT_W     = 40;  // sum width, signed integer format (Q40.0)

   localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B     = 2'd2;

   localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

   localparam logic STATUS_PRODUCT = 1'b0;
   localparam logic STATUS_REJECT  = 1'b1;

   // control tag that travels with each read through the pipeline
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             last_elem;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } tag_type;

   // finished product element from the accumulator
   typedef struct packed {
      logic                    valid;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [OUT_W-1:0] value;
      logic                    last;
   } res_type;

endpackage

// File: sv/mmul_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mmul_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/mmul_seq.sv
// sequencer: walks row, column and inner index of a product run
// depends on mmul_pkg
`timescale 1ns / 1ps

module mmul_seq #(
   parameter int MAX_DIM = 8,
   parameter int AW      = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        adv,
   input  logic [mmul_pkg::CFG_W-1:0]  num_rows,
   input  logic [mmul_pkg::CFG_W-1:0]  num_inner,
   input  logic [mmul_pkg::CFG_W-1:0]  num_cols,
   output logic [AW-1:0]               a_addr,
   output logic [AW-1:0]               b_addr,
   output mmul_pkg::tag_type           tag
);

   localparam int PW = AW + mmul_pkg::CFG_W;

   logic                       active_ff, active_in;
   logic [mmul_pkg::CFG_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                       k_end, j_end, i_end;
   logic [PW-1:0]              a_full, b_full;

   assign k_end = (k_ff == num_inner - 1'b1);
   assign j_end = (j_ff == num_cols - 1'b1);
   assign i_end = (i_ff == num_rows - 1'b1);

   always_comb begin
      active_in = active_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      if (start) begin
         active_in = 1'b1;
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
      end else if (active_ff && adv) begin
         if (!k_end) begin
            k_in = k_ff + 1'b1;
         end else begin
            k_in = '0;
            if (!j_end) begin
               j_in = j_ff + 1'b1;
            end else begin
               j_in = '0;
               if (!i_end) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
      end else begin
         active_ff <= active_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
      end
   end

   // row-major store addressing
   assign a_full = PW'(i_ff) * PW'(MAX_DIM) + PW'(k_ff);
   assign b_full = PW'(k_ff) * PW'(MAX_DIM) + PW'(j_ff);
   assign a_addr = a_full[AW-1:0];
   assign b_addr = b_full[AW-1:0];

   always_comb begin
      tag.valid     = active_ff;
      tag.first     = (k_ff == '0);
      tag.last_k    = k_end;
      tag.last_elem = k_end && j_end && i_end;
      tag.row       = i_ff[mmul_pkg::ROW_W-1:0];
      tag.col       = j_ff[mmul_pkg::COL_W-1:0];
   end

endmodule

// File: sv/mmul_mac.sv
// shared multiply-accumulate unit: one product per cycle while adv is high, saturating sum
// depends on mmul_pkg
`timescale 1ns / 1ps

module mmul_mac #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  mmul_pkg::tag_type      tag,
   input  logic [ELEM_WIDTH-1:0]  a_data,
   input  logic [ELEM_WIDTH-1:0]  b_data,
   output mmul_pkg::res_type      res
);

   localparam int PRODW = 2 * ELEM_WIDTH;
   localparam int SUMW  = (PRODW > mmul_pkg::OUT_W ? PRODW : mmul_pkg::OUT_W) + 1;
   localparam logic signed [SUMW-1:0] SAT_HI =
      {{(SUMW - mmul_pkg::OUT_W + 1){1'b0}}, {(mmul_pkg::OUT_W - 1){1'b1}}};
   localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

   mmul_pkg::tag_type                tag1_ff, tag1_in, tag2_ff, tag2_in;
   logic signed [PRODW-1:0]          product_ff, product_in;
   logic signed [mmul_pkg::OUT_W-1:0] acc_ff, acc_in, base, sat_sum;
   logic signed [SUMW-1:0]           sum;

   // stage 1 aligns with ram read data, stage 2 holds the product
   always_comb begin
      tag1_in    = adv ? tag : tag1_ff;
      tag2_in    = adv ? tag1_ff : tag2_ff;
      product_in = adv ? $signed(a_data) * $signed(b_data) : product_ff;
   end

   assign base = tag2_ff.first ? '0 : acc_ff;
   assign sum  = SUMW'(base) + SUMW'(product_ff);

   always_comb begin
      if (sum > SAT_HI) begin
         sat_sum = SAT_HI[mmul_pkg::OUT_W-1:0];
      end else if (sum < SAT_LO) begin
         sat_sum = SAT_LO[mmul_pkg::OUT_W-1:0];
      end else begin
         sat_sum = sum[mmul_pkg::OUT_W-1:0];
      end
   end

   assign acc_in = (adv && tag2_ff.valid) ? sat_sum : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag2_in;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      acc_ff     <= acc_in;
   end

   always_comb begin
      res.valid = adv && tag2_ff.valid && tag2_ff.last_k;
      res.row   = tag2_ff.row;
      res.col   = tag2_ff.col;
      res.value = sat_sum;
      res.last  = tag2_ff.last_elem;
   end

endmodule

// File: sv/matrix_multiply_core.sv
// top level of the matrix multiply core: registers, stores and result stage
// depends on mmul_pkg, mmul_ram, mmul_seq, mmul_mac
//
// channel  direction  handshake          payload
// req      in         req_valid/stall    command, row_index, col_index, element_value
// rsp      out        rsp_valid/stall    status, out_row, out_col, out_value, last
// csr      in         csr_write          csr_index, csr_data
//
// a write item is stored as it is taken; a rejected write puts one item on rsp
// a compute item runs rows x cols x inner products through the single shared
// multiplier, one product per cycle while a waiting result is not held by a stalled rsp
// req is stalled for the whole run and while a result waits on a stalled rsp
// a stalled rsp freezes the whole multiply pipeline
// reset clears control and the dimension registers (all to 8); stores are not cleared
`timescale 1ns / 1ps

module matrix_multiply_core #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mmul_pkg::CMD_W-1:0]           req_command,
   input  logic [mmul_pkg::ROW_W-1:0]           req_row_index,
   input  logic [mmul_pkg::COL_W-1:0]           req_col_index,
   input  logic signed [mmul_pkg::ELEM_IN_W-1:0] req_element_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_status,
   output logic [mmul_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [mmul_pkg::COL_W-1:0]           rsp_out_col,
   output logic signed [mmul_pkg::OUT_W-1:0]    rsp_out_value,
   output logic                                 rsp_last,
   input  logic                                 csr_write,
   input  logic [mmul_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mmul_pkg::CFG_W-1:0]           csr_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int PW    = AW + mmul_pkg::CFG_W;
   localparam logic [mmul_pkg::CFG_W-1:0] DIM_CAP =
      MAX_DIM > 15 ? 4'd15 : mmul_pkg::CFG_W'(MAX_DIM);

   logic [mmul_pkg::CFG_W-1:0] rows_a_ff, rows_a_in, inner_ff, inner_in, cols_b_ff, cols_b_in;
   logic [mmul_pkg::CFG_W-1:0] nr, nk, nc;

   logic                               busy_ff, busy_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_status_ff, rsp_status_in;
   logic [mmul_pkg::ROW_W-1:0]         rsp_row_ff, rsp_row_in;
   logic [mmul_pkg::COL_W-1:0]         rsp_col_ff, rsp_col_in;
   logic signed [mmul_pkg::OUT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                       adv, req_take, is_write, is_compute, is_a, index_bad;
   logic                       write_ok;
   logic [mmul_pkg::CFG_W-1:0] lim_r, lim_c;
   logic [PW-1:0]              wr_full;
   logic [AW-1:0]              wr_addr, a_addr, b_addr;
   logic [mmul_pkg::ELEM_MAX_W-1:0] elem_wide;
   logic [ELEM_WIDTH-1:0]      elem_store, a_data, b_data;
   mmul_pkg::tag_type          tag;
   mmul_pkg::res_type          res;

   // dimension registers
   always_comb begin
      rows_a_in = rows_a_ff;
      inner_in  = inner_ff;
      cols_b_in = cols_b_ff;
      if (csr_write) begin
         case (csr_index)
            mmul_pkg::CSR_ROWS_A:     rows_a_in = csr_data;
            mmul_pkg::CSR_INNER_SIZE: inner_in  = csr_data;
            mmul_pkg::CSR_COLS_B:     cols_b_in = csr_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, above the store size acts as the store size
   function automatic logic [mmul_pkg::CFG_W-1:0] clamp_dim(
      input logic [mmul_pkg::CFG_W-1:0] v,
      input logic [mmul_pkg::CFG_W-1:0] cap
   );
      logic [mmul_pkg::CFG_W-1:0] r;
      if (v == '0) begin
         r = mmul_pkg::CFG_W'(1);
      end else if (v > cap) begin
         r = cap;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign nr = clamp_dim(rows_a_ff, DIM_CAP);
   assign nk = clamp_dim(inner_ff, DIM_CAP);
   assign nc = clamp_dim(cols_b_ff, DIM_CAP);

   // request decode
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy_ff || (rsp_valid_ff && rsp_stall);
   assign req_take   = req_valid && !req_stall;
   assign is_a       = (req_command == mmul_pkg::CMD_WRITE_A);
   assign is_write   = is_a || (req_command == mmul_pkg::CMD_WRITE_B);
   assign is_compute = (req_command == mmul_pkg::CMD_COMPUTE);
   assign lim_r      = is_a ? nr : nk;
   assign lim_c      = is_a ? nk : nc;
   assign index_bad  = ({1'b0, req_row_index} >= lim_r) || ({1'b0, req_col_index} >= lim_c);
   assign write_ok   = req_take && is_write && !index_bad;

   assign wr_full    = PW'(req_row_index) * PW'(MAX_DIM) + PW'(req_col_index);
   assign wr_addr    = wr_full[AW-1:0];
   assign elem_wide  = {{(mmul_pkg::ELEM_MAX_W - mmul_pkg::ELEM_IN_W){1'b0}}, req_element_value};
   assign elem_store = elem_wide[ELEM_WIDTH-1:0];

   mmul_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (write_ok && is_a),
      .wr_addr (wr_addr),
      .wr_data (elem_store),
      .rd_en   (adv),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   mmul_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (write_ok && !is_a),
      .wr_addr (wr_addr),
      .wr_data (elem_store),
      .rd_en   (adv),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   mmul_seq #(.MAX_DIM(MAX_DIM), .AW(AW)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take && is_compute),
      .adv       (adv),
      .num_rows  (nr),
      .num_inner (nk),
      .num_cols  (nc),
      .a_addr    (a_addr),
      .b_addr    (b_addr),
      .tag       (tag)
   );

   mmul_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .tag    (tag),
      .a_data (a_data),
      .b_data (b_data),
      .res    (res)
   );

   // result stage
   always_comb begin
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_take && is_compute) begin
         busy_in = 1'b1;
      end
      if (req_take && is_write && index_bad) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = mmul_pkg::STATUS_REJECT;
         rsp_row_in    = '0;
         rsp_col_in    = '0;
         rsp_value_in  = '0;
         rsp_last_in   = 1'b0;
      end else if (res.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = mmul_pkg::STATUS_PRODUCT;
         rsp_row_in    = res.row;
         rsp_col_in    = res.col;
         rsp_value_in  = res.value;
         rsp_last_in   = res.last;
         if (res.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mmul_pkg::DIM_RESET;
         inner_ff     <= mmul_pkg::DIM_RESET;
         cols_b_ff    <= mmul_pkg::DIM_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_ff     <= inner_in;
         cols_b_ff    <= cols_b_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_result_only_in_run : assert property (@(posedge clock) disable iff (reset)
      res.valid |-> busy_ff)
      else $error("product element outside a compute run");

   a_reject_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == mmul_pkg::STATUS_REJECT)
         |-> (rsp_value_ff == '0 && !rsp_last_ff && rsp_row_ff == '0 && rsp_col_ff == '0))
      else $error("rejected write item carries a payload");

   a_compute_busy : assert property (@(posedge clock) disable iff (reset)
      (req_take && is_compute) |=> busy_ff)
      else $error("compute item did not start a run");

   a_no_store_write_in_run : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !write_ok)
      else $error("store written during a compute run");
`endif

endmodule

// File: sim/tb_matrix_multiply_core.sv
// testbench for matrix_multiply_core: a directed stimulus table, then random phases
// per dimension setting, every result checked against a fixed expected item or an internal product predictor
// depends on mmul_pkg and the matrix_multiply_core rtl
`timescale 1ns / 1ps

module tb_matrix_multiply_core;

   localparam int DIM          = 8;
   localparam int RANDOM_ITEMS = 360;
   localparam int SETTLE       = 8;
   localparam int DRAIN        = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam logic [mmul_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam longint SUM_MAX = 64'sd549755813887;
   localparam longint SUM_MIN = -64'sd549755813888;

   typedef struct packed {
      logic                       status;
      logic [mmul_pkg::ROW_W-1:0] row;
      logic [mmul_pkg::COL_W-1:0] col;
      logic [mmul_pkg::OUT_W-1:0] value;
      logic                       last;
   } element_type;

   typedef struct packed {
      bit                             is_csr;
      logic [mmul_pkg::CSR_IDX_W-1:0] sel;
      logic [mmul_pkg::CFG_W-1:0]     dim;
      logic [mmul_pkg::CMD_W-1:0]     cmd;
      logic [mmul_pkg::ROW_W-1:0]     row;
      logic [mmul_pkg::COL_W-1:0]     col;
      logic [mmul_pkg::ELEM_IN_W-1:0] value;
      bit                             fixed;
      element_type                    res;
   } stim_row_type;

   localparam element_type NO_RESULT = '0;
   localparam element_type REJECTED  = '{mmul_pkg::STATUS_REJECT, 3'd0, 3'd0, 40'd0, 1'b0};

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [mmul_pkg::CMD_W-1:0]            req_command = mmul_pkg::CMD_WRITE_A;
   logic [mmul_pkg::ROW_W-1:0]            req_row_index = '0;
   logic [mmul_pkg::COL_W-1:0]            req_col_index = '0;
   logic signed [mmul_pkg::ELEM_IN_W-1:0] req_element_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_status;
   logic [mmul_pkg::ROW_W-1:0]            rsp_out_row;
   logic [mmul_pkg::COL_W-1:0]            rsp_out_col;
   logic signed [mmul_pkg::OUT_W-1:0]     rsp_out_value;
   logic                                  rsp_last;
   logic                                  csr_write = 1'b0;
   logic [mmul_pkg::CSR_IDX_W-1:0]        csr_index = mmul_pkg::CSR_ROWS_A;
   logic [mmul_pkg::CFG_W-1:0]            csr_data = '0;

   // predictor state
   logic signed [mmul_pkg::ELEM_IN_W-1:0] a_elem [DIM*DIM];
   logic signed [mmul_pkg::ELEM_IN_W-1:0] b_elem [DIM*DIM];
   bit                                    a_set [DIM*DIM];
   bit                                    b_set [DIM*DIM];
   logic [mmul_pkg::CFG_W-1:0]            dim_reg [3] =
      '{mmul_pkg::DIM_RESET, mmul_pkg::DIM_RESET, mmul_pkg::DIM_RESET};
   element_type                           owed_results [$];
   stim_row_type                          stim_table [$];

   int error_count = 0;
   int idle_cycles = 0;
   int rsp_taken = 0;
   int rsp_seen = 0;
   int rsp_hold = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   matrix_multiply_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .req_element_value(req_element_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col), .rsp_out_value(rsp_out_value),
      .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int span_of(input logic [mmul_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
   endfunction

   // expected results of one accepted item, state updated as the core does
   function automatic void apply_command(input logic [mmul_pkg::CMD_W-1:0] cmd,
                                         input logic [mmul_pkg::ROW_W-1:0] row,
                                         input logic [mmul_pkg::COL_W-1:0] col,
                                         input logic [mmul_pkg::ELEM_IN_W-1:0] value);
      int          nr;
      int          nk;
      int          nc;
      int          lim_r;
      int          lim_c;
      int          addr;
      longint      acc;
      element_type res;
      nr = span_of(dim_reg[mmul_pkg::CSR_ROWS_A]);
      nk = span_of(dim_reg[mmul_pkg::CSR_INNER_SIZE]);
      nc = span_of(dim_reg[mmul_pkg::CSR_COLS_B]);
      case (cmd)
         mmul_pkg::CMD_WRITE_A, mmul_pkg::CMD_WRITE_B: begin
            lim_r = (cmd == mmul_pkg::CMD_WRITE_A) ? nr : nk;
            lim_c = (cmd == mmul_pkg::CMD_WRITE_A) ? nk : nc;
            addr = row * DIM + col;
            if (row >= lim_r || col >= lim_c) begin
               owed_results.push_back(REJECTED);
            end else if (cmd == mmul_pkg::CMD_WRITE_A) begin
               a_elem[addr] = value;
               a_set[addr] = 1'b1;
            end else begin
               b_elem[addr] = value;
               b_set[addr] = 1'b1;
            end
         end
         mmul_pkg::CMD_COMPUTE: begin
            for (int i = 0; i < nr; i++) begin
               for (int j = 0; j < nc; j++) begin
                  acc = 0;
                  for (int k = 0; k < nk; k++) begin
                     acc += longint'(a_elem[i*DIM+k]) * longint'(b_elem[k*DIM+j]);
                     if (acc > SUM_MAX) acc = SUM_MAX;
                     if (acc < SUM_MIN) acc = SUM_MIN;
                  end
                  res.status = mmul_pkg::STATUS_PRODUCT;
                  res.row = mmul_pkg::ROW_W'(i);
                  res.col = mmul_pkg::COL_W'(j);
                  res.value = acc[mmul_pkg::OUT_W-1:0];
                  res.last = (i == nr - 1) && (j == nc - 1);
                  owed_results.push_back(res);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [mmul_pkg::ELEM_IN_W-1:0] rand_elem();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
         default: return mmul_pkg::ELEM_IN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [mmul_pkg::CFG_W-1:0] rand_dim();
      if ($urandom_range(0, 3) == 0) return mmul_pkg::CFG_W'($urandom_range(0, 15));
      return mmul_pkg::CFG_W'($urandom_range(1, 4));
   endfunction

   task automatic send_item(input logic [mmul_pkg::CMD_W-1:0] cmd,
                            input logic [mmul_pkg::ROW_W-1:0] row,
                            input logic [mmul_pkg::COL_W-1:0] col,
                            input logic [mmul_pkg::ELEM_IN_W-1:0] value,
                            input bit fixed, input element_type res);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_row_index <= row;
      req_col_index <= col;
      req_element_value <= value;
      do @(posedge clock); while (req_stall);
      if (fixed) owed_results.push_back(res);
      else apply_command(cmd, row, col, value);
   endtask

   // sender holds off until every owed result is back and the core has settled
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_dim(input logic [mmul_pkg::CSR_IDX_W-1:0] sel,
                            input logic [mmul_pkg::CFG_W-1:0] value);
      settle_idle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_data <= value;
      dim_reg[sel] = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic row_csr(input logic [mmul_pkg::CSR_IDX_W-1:0] sel,
                          input logic [mmul_pkg::CFG_W-1:0] value);
      stim_table.push_back('{1'b1, sel, value, CMD_UNUSED, 3'd0, 3'd0, 16'd0, 1'b0,
                             NO_RESULT});
   endtask

   task automatic row_req(input logic [mmul_pkg::CMD_W-1:0] cmd,
                          input logic [mmul_pkg::ROW_W-1:0] row,
                          input logic [mmul_pkg::COL_W-1:0] col,
                          input logic [mmul_pkg::ELEM_IN_W-1:0] value,
                          input bit fixed, input element_type res);
      stim_table.push_back('{1'b0, mmul_pkg::CSR_ROWS_A, 4'd0, cmd, row, col, value,
                             fixed, res});
   endtask

   task automatic random_item(inout int computes, inout int counted);
      int                         nr;
      int                         nk;
      int                         nc;
      int                         pick;
      int                         missing [$];
      logic [mmul_pkg::CMD_W-1:0] cmd;
      logic [mmul_pkg::ROW_W-1:0] row;
      logic [mmul_pkg::COL_W-1:0] col;
      nr = span_of(dim_reg[mmul_pkg::CSR_ROWS_A]);
      nk = span_of(dim_reg[mmul_pkg::CSR_INNER_SIZE]);
      nc = span_of(dim_reg[mmul_pkg::CSR_COLS_B]);
      for (int r = 0; r < nr; r++)
         for (int k = 0; k < nk; k++)
            if (!a_set[r*DIM+k]) missing.push_back(r * DIM + k);
      for (int k = 0; k < nk; k++)
         for (int c = 0; c < nc; c++)
            if (!b_set[k*DIM+c]) missing.push_back(DIM * DIM + k * DIM + c);
      row = mmul_pkg::ROW_W'($urandom_range(0, 7));
      col = mmul_pkg::COL_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // noise: any write or the unused command
         cmd = mmul_pkg::CMD_W'($urandom_range(0, 3));
         if (cmd == mmul_pkg::CMD_COMPUTE) cmd = CMD_UNUSED;
      end else if (missing.size() > 0) begin
         pick = missing[$urandom_range(0, missing.size() - 1)];
         cmd = (pick >= DIM * DIM) ? mmul_pkg::CMD_WRITE_B : mmul_pkg::CMD_WRITE_A;
         row = mmul_pkg::ROW_W'((pick % (DIM * DIM)) / DIM);
         col = mmul_pkg::COL_W'(pick % DIM);
      end else if (pick <= 2) begin
         cmd = mmul_pkg::CMD_COMPUTE;
         computes++;
      end else begin
         cmd = $urandom_range(0, 1) ? mmul_pkg::CMD_WRITE_B : mmul_pkg::CMD_WRITE_A;
         if ($urandom_range(0, 4) != 0) begin
            row = mmul_pkg::ROW_W'($urandom_range(0,
                     ((cmd == mmul_pkg::CMD_WRITE_A) ? nr : nk) - 1));
            col = mmul_pkg::COL_W'($urandom_range(0,
                     ((cmd == mmul_pkg::CMD_WRITE_A) ? nk : nc) - 1));
         end
      end
      send_item(cmd, row, col, rand_elem(), 1'b0, NO_RESULT);
      if (cmd != CMD_UNUSED) counted++;
   endtask

   // result checker
   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = rsp_taken + 1;
         if (owed_results.size() == 0) begin
            $error("unexpected result item: status %0d row %0d col %0d value %0d",
                   rsp_status, rsp_out_row, rsp_out_col, rsp_out_value);
            error_count++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
               error_count++;
            end
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %0d, got %0d", $signed(want.value), rsp_out_value);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // receiver stall, redrawn after every accepted result
   always @(negedge clock) begin
      if (rsp_seen != rsp_taken) begin
         rsp_seen = rsp_taken;
         rsp_hold = rx_steady ? 0 : $urandom_range(0, 11);
      end
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tb_matrix_multiply_core: FAIL");
      $finish;
   end

   initial begin
      int phase;
      int computes;
      int counted;
      // single element product, extremes and rejected writes
      row_csr(mmul_pkg::CSR_ROWS_A, 4'd1);
      row_csr(mmul_pkg::CSR_INNER_SIZE, 4'd1);
      row_csr(mmul_pkg::CSR_COLS_B, 4'd1);
      row_req(mmul_pkg::CMD_WRITE_A, 3'd0, 3'd0, 16'h8000, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_WRITE_B, 3'd0, 3'd0, 16'h8000, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1,
              '{mmul_pkg::STATUS_PRODUCT, 3'd0, 3'd0, 40'sd1073741824, 1'b1});
      row_req(mmul_pkg::CMD_WRITE_A, 3'd1, 3'd0, 16'h7fff, 1'b1, REJECTED);
      row_req(mmul_pkg::CMD_WRITE_A, 3'd0, 3'd1, 16'h1234, 1'b1, REJECTED);
      row_req(mmul_pkg::CMD_WRITE_B, 3'd1, 3'd0, 16'h8000, 1'b1, REJECTED);
      row_req(mmul_pkg::CMD_WRITE_B, 3'd0, 3'd1, 16'hffff, 1'b1, REJECTED);
      row_req(mmul_pkg::CMD_WRITE_A, 3'd7, 3'd7, 16'h7fff, 1'b1, REJECTED);
      row_req(CMD_UNUSED, 3'd7, 3'd7, 16'hffff, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_WRITE_A, 3'd0, 3'd0, 16'h7fff, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_COMPUTE, 3'd7, 3'd7, 16'h5a5a, 1'b0, NO_RESULT);
      // zero dimension acts as one
      row_csr(mmul_pkg::CSR_ROWS_A, 4'd0);
      row_csr(mmul_pkg::CSR_INNER_SIZE, 4'd2);
      row_csr(mmul_pkg::CSR_COLS_B, 4'd2);
      row_req(mmul_pkg::CMD_WRITE_A, 3'd1, 3'd0, 16'h0100, 1'b1, REJECTED);
      row_req(mmul_pkg::CMD_WRITE_A, 3'd0, 3'd1, 16'h0001, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_WRITE_B, 3'd1, 3'd0, 16'hffff, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_WRITE_B, 3'd0, 3'd1, 16'h0100, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_WRITE_B, 3'd1, 3'd1, 16'h7fff, 1'b0, NO_RESULT);
      row_req(mmul_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, NO_RESULT);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr) begin
            write_dim(stim_table[i].sel, stim_table[i].dim);
         end else begin
            send_item(stim_table[i].cmd, stim_table[i].row, stim_table[i].col,
                      stim_table[i].value, stim_table[i].fixed, stim_table[i].res);
         end
      end

      phase = 0;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (phase == 0) begin
            write_dim(mmul_pkg::CSR_ROWS_A, 4'd2);
            write_dim(mmul_pkg::CSR_INNER_SIZE, 4'd3);
            write_dim(mmul_pkg::CSR_COLS_B, 4'd2);
         end else if (phase == 1) begin
            // register values above the maximum act as the maximum
            write_dim(mmul_pkg::CSR_ROWS_A, 4'd15);
            write_dim(mmul_pkg::CSR_INNER_SIZE, 4'd8);
            write_dim(mmul_pkg::CSR_COLS_B, 4'd15);
         end else begin
            write_dim(mmul_pkg::CSR_ROWS_A, rand_dim());
            write_dim(mmul_pkg::CSR_INNER_SIZE, rand_dim());
            write_dim(mmul_pkg::CSR_COLS_B, rand_dim());
         end
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         computes = 0;
         while (computes < 2 && counted < RANDOM_ITEMS) random_item(computes, counted);
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (error_count == 0 && owed_results.size() == 0) begin
         $display("tb_matrix_multiply_core: PASS");
      end else begin
         $display("tb_matrix_multiply_core: FAIL");
      end
      $finish;
   end

endmodule

// File: matrix_multiply_core.f
sv/mmul_pkg.sv
sv/mmul_ram.sv
sv/mmul_seq.sv
sv/mmul_mac.sv
sv/matrix_multiply_core.sv
sim/tb_matrix_multiply_core.sv
